### hdl/lphs_pkg.sv
// Shared types and constants for the linear probing hash set.
// Used by the channel interfaces, the top level and the port checker.
`default_nettype none

package lphs_pkg;

   // Field widths fixed by the request and result formats.
   localparam int KEY_W       = 32;
   localparam int SIZE_W      = 11;
   localparam int COUNT_W     = 11;
   localparam int OUTCOME_W   = 3;

   // Default table depth and the table size after reset.
   localparam int                DEFAULT_DEPTH = 1024;
   localparam logic [SIZE_W-1:0] SIZE_RESET    = 11'd1024;

   // Home slot divider: key bits consumed per cycle.
   localparam int BITS_PER_CYCLE = 4;
   localparam int DIV_STEPS      = KEY_W / BITS_PER_CYCLE;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   // Request type code for a membership query (insert is the other code).
   localparam logic REQ_QUERY = 1'b1;

   // Result status codes.
   typedef enum logic [OUTCOME_W-1:0] {
      OUT_INSERTED  = 3'd0,
      OUT_PRESENT   = 3'd1,
      OUT_FULL      = 3'd2,
      OUT_NOT_FOUND = 3'd3,
      OUT_ZERO_KEY  = 3'd4
   } outcome_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_PROBE,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### hdl/lphs_ifs.sv
// Valid/ready channel interfaces for requests, results and the size register.
// Depends on lphs_pkg for field widths.
`default_nettype none

// Request channel: one insert or query per accepted transfer.
interface lphs_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [lphs_pkg::KEY_W-1:0]   key_value;

   modport source (output valid, output req_type, output key_value, input ready);
   modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

// Result channel: one result per request.
interface lphs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lphs_pkg::OUTCOME_W-1:0] outcome;
   logic                           answer;
   logic [lphs_pkg::COUNT_W-1:0]   occupied_count;

   modport source (output valid, output outcome, output answer, output occupied_count,
                   input ready);
   modport sink   (input valid, input outcome, input answer, input occupied_count,
                   output ready);
endinterface

// Configuration write channel for the table size register.
interface lphs_csr_if;
   logic                          valid;
   logic                          ready;
   logic [lphs_pkg::SIZE_W-1:0]   table_size;

   modport source (output valid, output table_size, input ready);
   modport sink   (input valid, input table_size, output ready);
endinterface

`default_nettype wire

### hdl/linear_probe_hash_set.sv
// Open-addressing hash set of nonzero 32-bit keys with linear probing.
// A request runs through the home slot divider and then probes 1 to table size slots,
// one probe per cycle through the slot memory read port; a zero key skips both. One
// request at a time: the next is taken after the result is registered. Synchronous
// reset, and every size register write, starts a clearing pass over all TABLE_DEPTH
// slots during which no request is taken.
`default_nettype none

module linear_probe_hash_set #(
   parameter int TABLE_DEPTH = lphs_pkg::DEFAULT_DEPTH
) (
   input  wire        clock,
   input  wire        reset,
   lphs_req_if.sink   req_chan,
   lphs_rsp_if.source rsp_chan,
   lphs_csr_if.sink   csr_chan
);
   import lphs_pkg::*;

   localparam int ADDR_W    = $clog2(TABLE_DEPTH);
   localparam int EFF_W     = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W     = (EFF_W > SIZE_W) ? EFF_W : SIZE_W;
   localparam int REM_W     = EFF_W + 1;
   localparam int SAT_W     = (EFF_W > COUNT_W) ? EFF_W : COUNT_W;
   localparam int COUNT_MAX = (1 << COUNT_W) - 1;

   // Clamp the written size into the range 1 to TABLE_DEPTH.
   function automatic logic [EFF_W-1:0] eff_size(input logic [SIZE_W-1:0] ts);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(ts);
      if (ts == '0) begin
         return EFF_W'(1);
      end else if (ext > CMP_W'(TABLE_DEPTH)) begin
         return EFF_W'(TABLE_DEPTH);
      end else begin
         return EFF_W'(ext);
      end
   endfunction

   // Registers and their next values.
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [EFF_W-1:0]   size_ff, size_in;
   logic [EFF_W-1:0]   fill_ff, fill_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               query_ff, query_in;
   logic [KEY_W-1:0]   div_key_ff, div_key_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [EFF_W-1:0]   rem_ff, rem_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [ADDR_W-1:0]  steps_ff, steps_in;
   outcome_type        outcome_ff, outcome_in;
   logic               answer_ff, answer_in;
   logic               rsp_valid_ff, rsp_valid_in;
   outcome_type        rsp_outcome_ff, rsp_outcome_in;
   logic               rsp_answer_ff, rsp_answer_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Slot memory and its registered read data.
   logic [KEY_W-1:0]   slot_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [KEY_W-1:0]   mem_wdata;
   logic               mem_we;

   // Handshakes and derived conditions.
   logic               req_fire;
   logic               csr_fire;
   logic               rsp_load;
   logic               clear_last;
   logic               div_last;
   logic [EFF_W-1:0]   div_rem_next;
   logic [EFF_W-1:0]   pos_inc;
   logic [ADDR_W-1:0]  pos_next;
   logic               slot_empty;
   logic               slot_match;
   logic               probe_last;
   logic [SAT_W-1:0]   fill_ext;
   logic [COUNT_W-1:0] fill_sat;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign csr_fire   = csr_chan.valid && csr_chan.ready;
   assign clear_last = (clr_addr_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign div_last   = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Restoring remainder, several key bits per cycle, most significant first.
   always_comb begin
      logic [REM_W-1:0] trial;
      logic [EFF_W-1:0] acc;
      acc = rem_ff;
      for (int i = 0; i < BITS_PER_CYCLE; i++) begin
         trial = {acc, div_key_ff[KEY_W-1-i]};
         if (trial >= REM_W'(size_ff)) begin
            trial = trial - REM_W'(size_ff);
         end
         acc = trial[EFF_W-1:0];
      end
      div_rem_next = acc;
   end

   // Probe position with wrap at the table size.
   assign pos_inc  = EFF_W'(pos_ff) + EFF_W'(1);
   assign pos_next = (pos_inc == size_ff) ? '0 : pos_inc[ADDR_W-1:0];

   // Slot tests on the data read for the current probe.
   assign slot_empty = (rd_data_ff == '0);
   assign slot_match = (rd_data_ff == key_ff);
   assign probe_last = (EFF_W'(steps_ff) == (size_ff - EFF_W'(1)));

   // Occupancy count saturated to the result field.
   assign fill_ext = SAT_W'(fill_ff);
   assign fill_sat = (fill_ext > SAT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                     : COUNT_W'(fill_ext);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_chan.key_value == '0) ? ST_DONE : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_last) state_in = ST_PROBE;
         end
         ST_PROBE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (slot_empty || slot_match || probe_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      // A size write restarts the clearing pass.
      if (csr_fire) state_in = ST_CLEAR;
   end

   // Handshake and memory controls.
   always_comb begin
      req_chan.ready = 1'b0;
      csr_chan.ready = 1'b1;
      rsp_load       = 1'b0;
      mem_raddr      = pos_ff;
      mem_we         = 1'b0;
      mem_waddr      = pos_ff;
      mem_wdata      = key_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         ST_CHECK: begin
            mem_raddr = pos_next;
            mem_we    = slot_empty && !query_ff;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      clr_addr_in    = clr_addr_ff;
      size_in        = size_ff;
      fill_in        = fill_ff;
      key_in         = key_ff;
      query_in       = query_ff;
      div_key_in     = div_key_ff;
      div_cnt_in     = div_cnt_ff;
      rem_in         = rem_ff;
      pos_in         = pos_ff;
      steps_in       = steps_ff;
      outcome_in     = outcome_ff;
      answer_in      = answer_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_answer_in  = rsp_answer_ff;
      rsp_count_in   = rsp_count_ff;

      // A taken result frees the output register.
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               key_in     = req_chan.key_value;
               query_in   = (req_chan.req_type == REQ_QUERY);
               div_key_in = req_chan.key_value;
               div_cnt_in = '0;
               rem_in     = '0;
               outcome_in = OUT_ZERO_KEY;
               answer_in  = 1'b0;
            end
         end
         ST_DIVIDE: begin
            div_key_in = div_key_ff << BITS_PER_CYCLE;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            rem_in     = div_rem_next;
            pos_in     = div_rem_next[ADDR_W-1:0];
            steps_in   = '0;
         end
         ST_CHECK: begin
            if (slot_empty) begin
               if (query_ff) begin
                  outcome_in = OUT_NOT_FOUND;
                  answer_in  = 1'b0;
               end else begin
                  outcome_in = OUT_INSERTED;
                  answer_in  = 1'b1;
                  fill_in    = fill_ff + EFF_W'(1);
               end
            end else if (slot_match) begin
               outcome_in = OUT_PRESENT;
               answer_in  = query_ff;
            end else if (probe_last) begin
               outcome_in = query_ff ? OUT_NOT_FOUND : OUT_FULL;
               answer_in  = 1'b0;
            end else begin
               pos_in   = pos_next;
               steps_in = steps_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = outcome_ff;
               rsp_answer_in  = answer_ff;
               rsp_count_in   = fill_sat;
            end
         end
         default: begin
         end
      endcase

      // A size write takes the clamped size and empties the table.
      if (csr_fire) begin
         size_in     = eff_size(csr_chan.table_size);
         fill_in     = '0;
         clr_addr_in = '0;
      end
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         size_ff      <= eff_size(SIZE_RESET);
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         size_ff      <= size_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      query_ff       <= query_in;
      div_key_ff     <= div_key_in;
      div_cnt_ff     <= div_cnt_in;
      rem_ff         <= rem_in;
      pos_ff         <= pos_in;
      steps_ff       <= steps_in;
      outcome_ff     <= outcome_in;
      answer_ff      <= answer_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_answer_ff  <= rsp_answer_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // Slot memory: one write port, one registered read port. Requests are handled
   // one at a time, so a write always lands before any later read of that slot.
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= slot_mem[mem_raddr];
   end

   // Result channel outputs.
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.outcome        = rsp_outcome_ff;
   assign rsp_chan.answer         = rsp_answer_ff;
   assign rsp_chan.occupied_count = rsp_count_ff;

endmodule

`default_nettype wire

### hdl/lphs_checker.sv
// Port-level checker for the linear probing hash set, bound to its top level.
// Depends on lphs_pkg for field widths.
`default_nettype none

module lphs_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_ready,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire [lphs_pkg::OUTCOME_W-1:0] rsp_outcome,
   input wire                           rsp_answer,
   input wire [lphs_pkg::COUNT_W-1:0]   rsp_count,
   input wire                           csr_valid,
   input wire                           csr_ready
);
   import lphs_pkg::*;

   // Reset starts the clearing pass, so no request is taken right after it.
   a_reset_clears: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request ready right after reset");

   // A size write starts a clearing pass that holds off requests.
   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> !req_ready)
      else $error("request ready right after a size write");

   // Requests are handled one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in progress");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_outcome) && $stable(rsp_answer) && $stable(rsp_count)))
      else $error("stalled result changed or dropped");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_outcome (rsp_chan.outcome),
   .rsp_answer  (rsp_chan.answer),
   .rsp_count   (rsp_chan.occupied_count),
   .csr_valid   (csr_chan.valid),
   .csr_ready   (csr_chan.ready)
);

`default_nettype wire
